/* hw/rtl/wrhf_pkg.sv */
`default_nettype none
package wrhf_pkg;

  typedef enum logic [1:0] {
    CMD_ADVANCE = 2'd0,
    CMD_RIPPLE  = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  localparam logic [4:0] DampResetShift = 5'd12;

  // grid side, tied to the 7-bit coordinate ports
  localparam int GridSize = 128;

  // queued job between front end and engine
  typedef struct packed {
    cmd_e        cmd;
    logic        ok;
    logic [6:0]  x;
    logic [6:0]  z;
    logic [31:0] mag;
  } job_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_RIPPLE,
    ST_READ,
    ST_RESULT
  } eng_state_e;

endpackage
`default_nettype wire

/* hw/rtl/water_ripple_height_field.sv */
`default_nettype none
// Water ripple height field on a 128 by 128 grid. Commands enter through a
// two-beat queue; the grid engine runs them one at a time on two single-port-read
// grid memories. An advance updates each interior cell in turn through nine
// sequential reads on one read port. After reset a clearing pass zeroes
// both grids before the first command is taken; damping_shift may be written
// at any time the block is idle.
module water_ripple_height_field #(
  parameter int HEIGHT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [1:0]  command_i,
  input  logic [6:0]  cell_x_i,
  input  logic [6:0]  cell_z_i,
  input  logic [31:0] magnitude_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] height_o,
  output logic        in_range_o
);
  import wrhf_pkg::*;

  logic [4:0] shift_q;
  logic       job_valid, job_ready;
  job_t       job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) shift_q <= DampResetShift;
    else if (cfg_we_i) shift_q <= cfg_wdata_i;
  end

  wrhf_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .command_i, .cell_x_i, .cell_z_i,
    .magnitude_i, .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  wrhf_engine #(.HEIGHT_BITS(HEIGHT_BITS)) u_engine (
    .clk_i, .rst_ni, .shift_i(shift_q), .job_valid_i(job_valid),
    .job_ready_o(job_ready), .job_i(job), .valid_o, .ready_i, .height_o,
    .in_range_o
  );
endmodule
`default_nettype wire

/* hw/rtl/wrhf_front.sv */
`default_nettype none
module wrhf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [1:0]       command_i,
  input  logic [6:0]       cell_x_i,
  input  logic [6:0]       cell_z_i,
  input  logic [31:0]      magnitude_i,
  output logic             job_valid_o,
  input  logic             job_ready_i,
  output wrhf_pkg::job_t   job_o
);
  import wrhf_pkg::*;

  localparam logic [10:0] GMax = 11'(GridSize);

  // two-entry queue
  job_t       q_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  job_t       job_d;
  logic       push, pop;
  logic [10:0] xw, zw;

  always_comb begin
    xw = {4'd0, cell_x_i};
    zw = {4'd0, cell_z_i};
    job_d.cmd = cmd_e'(command_i);
    job_d.x   = cell_x_i;
    job_d.z   = cell_z_i;
    job_d.mag = magnitude_i;
    case (cmd_e'(command_i))
      CMD_RIPPLE: job_d.ok = (xw > 11'd2) && (xw < GMax - 11'd1) &&
                             (zw > 11'd2) && (zw < GMax - 11'd1);
      CMD_READ:   job_d.ok = (xw > 11'd2) && (xw < GMax) &&
                             (zw > 11'd2) && (zw < GMax);
      default:    job_d.ok = 1'b0;
    endcase
  end

  assign ready_o     = (cnt_q != 2'd2);
  assign push        = valid_i && ready_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= job_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/wrhf_engine.sv */
`default_nettype none
module wrhf_engine #(
  parameter int HEIGHT_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [4:0]     shift_i,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  wrhf_pkg::job_t job_i,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [31:0]    height_o,
  output logic           in_range_o
);
  import wrhf_pkg::*;

  localparam int CW    = $clog2(GridSize);
  localparam int AW    = 2 * CW;
  localparam int HB    = HEIGHT_BITS;
  localparam int SB    = HB + 3;
  localparam logic [CW-1:0] CLast = CW'(GridSize - 1);
  localparam logic [AW-1:0] ALast = AW'(GridSize * GridSize - 1);

  // two grid banks, bank select = current_is_b xor role
  logic [HB-1:0] mem_a [GridSize*GridSize];
  logic [HB-1:0] mem_b [GridSize*GridSize];

  eng_state_e state_q, state_d;
  logic       cur_b_q;
  job_t       job_q;
  logic [2:0]    ctr_q;      // ripple / read step
  logic [CW-1:0] i_q, j_q;
  logic [3:0]    ph_q;       // 0..8 reads, 9..11 pipeline, 12 write
  logic signed [SB-1:0] sum_q;
  logic signed [HB-1:0] prev_q, v_q, rd_q;
  logic [31:0] height_q;
  logic        ok_q;

  // clear walks both banks: each address twice, once per bank (lsb picks bank)
  logic [AW:0] clr_q;

  // read port address and bank
  logic [CW-1:0] ra_x, ra_z;
  logic          rd_b;
  logic [HB-1:0] rdata_a, rdata_b;
  logic          we;
  logic          we_b;
  logic [CW-1:0] wa_x, wa_z;
  logic [HB-1:0] wdata;
  logic [3:0]    ph_rd_q;

  always_comb begin
    ra_x = i_q; ra_z = j_q; rd_b = cur_b_q;
    case (ph_q)
      4'd0: begin ra_x = i_q - 1'b1; ra_z = j_q;        end
      4'd1: begin ra_x = i_q + 1'b1; ra_z = j_q;        end
      4'd2: begin ra_x = i_q;        ra_z = j_q + 1'b1; end
      4'd3: begin ra_x = i_q;        ra_z = j_q - 1'b1; end
      4'd4: begin ra_x = i_q - 1'b1; ra_z = j_q + 1'b1; end
      4'd5: begin ra_x = i_q - 1'b1; ra_z = j_q - 1'b1; end
      4'd6: begin ra_x = i_q + 1'b1; ra_z = j_q + 1'b1; end
      4'd7: begin ra_x = i_q + 1'b1; ra_z = j_q - 1'b1; end
      4'd8: begin ra_x = i_q;        ra_z = j_q; rd_b = ~cur_b_q; end
      default: ;
    endcase
    if (state_q == ST_READ) begin
      ra_x = job_q.x[CW-1:0]; ra_z = job_q.z[CW-1:0]; rd_b = cur_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a <= mem_a[{ra_x, ra_z}];
    rdata_b <= mem_b[{ra_x, ra_z}];
    if (we && !we_b) mem_a[{wa_x, wa_z}] <= wdata;
    if (we &&  we_b) mem_b[{wa_x, wa_z}] <= wdata;
  end

  logic          rd_b_q;
  logic [HB-1:0] rdata;
  assign rdata = rd_b_q ? rdata_b : rdata_a;

  // write port
  always_comb begin
    we = 1'b0; we_b = cur_b_q; wa_x = i_q; wa_z = j_q; wdata = v_q;
    case (state_q)
      ST_CLEAR: begin
        we = 1'b1; we_b = clr_q[0];
        wa_x = clr_q[AW -: CW]; wa_z = clr_q[CW:1];
        wdata = '0;
      end
      ST_SWEEP: begin
        we = (ph_q == 4'd12); we_b = ~cur_b_q;
      end
      ST_RIPPLE: begin
        we = 1'b1; wdata = job_q.mag[HB-1:0];
        wa_x = job_q.x[CW-1:0]; wa_z = job_q.z[CW-1:0];
        case (ctr_q)
          3'd1: begin wa_x = wa_x + 1'b1; wa_z = wa_z - 1'b1; end
          3'd2: begin wa_x = wa_x - 1'b1; wa_z = wa_z - 1'b1; end
          3'd3: begin wa_x = wa_x + 1'b1; wa_z = wa_z + 1'b1; end
          3'd4: begin wa_x = wa_x - 1'b1; wa_z = wa_z + 1'b1; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == {ALast, 1'b1}) state_d = ST_IDLE;
      ST_IDLE: begin
        if (job_valid_i) begin
          case (job_i.cmd)
            CMD_ADVANCE: state_d = ST_SWEEP;
            CMD_RIPPLE:  state_d = job_i.ok ? ST_RIPPLE : ST_RESULT;
            CMD_READ:    state_d = job_i.ok ? ST_READ : ST_RESULT;
            default:     state_d = ST_RESULT;
          endcase
        end
      end
      ST_SWEEP:  if (ph_q == 4'd12 && i_q == CLast - 1'b1 && j_q == CLast - 1'b1)
                   state_d = ST_RESULT;
      ST_RIPPLE: if (ctr_q == 3'd4) state_d = ST_RESULT;
      ST_READ:   if (ctr_q[0]) state_d = ST_RESULT;
      ST_RESULT: if (ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    job_ready_o = (state_q == ST_IDLE);
    valid_o     = (state_q == ST_RESULT);
    height_o    = height_q;
    in_range_o  = ok_q;
  end

  // datapath of one cell update
  logic signed [SB-1:0] q4, diff_w;
  logic signed [HB-1:0] dv;
  always_comb begin
    q4 = sum_q >>> 2;
    if (sum_q < 0 && sum_q[1:0] != 2'b00) q4 = q4 + SB'(1);
    diff_w = q4 - SB'(prev_q);
    dv = diff_w[HB-1:0];
  end

  always_ff @(posedge clk_i) begin
    rd_b_q  <= rd_b;
    ph_rd_q <= ph_q;
    if (state_q == ST_IDLE && job_valid_i) job_q <= job_i;
    if (state_q == ST_SWEEP) begin
      if (ph_rd_q <= 4'd7 && ph_q >= 4'd1 && ph_q <= 4'd9)
        sum_q <= (ph_q == 4'd1) ? SB'(signed'(rdata)) : sum_q + SB'(signed'(rdata));
      if (ph_q == 4'd9)  prev_q <= rdata;
      if (ph_q == 4'd10) rd_q   <= dv;
      if (ph_q == 4'd11) v_q    <= rd_q - (rd_q >>> shift_i);
    end
    if (state_q == ST_READ && ctr_q[0]) height_q <= 32'(signed'(rdata));
    if (state_q == ST_IDLE && job_valid_i) begin
      height_q <= '0;
      ok_q     <= job_i.ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cur_b_q <= 1'b0;
      clr_q   <= '0;
      ctr_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      ph_q    <= 4'd15;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
        end
        ST_IDLE: begin
          ctr_q <= '0;
          i_q   <= CW'(1);
          j_q   <= CW'(1);
          ph_q  <= (job_valid_i && job_i.cmd == CMD_ADVANCE) ? 4'd0 : 4'd15;
        end
        ST_SWEEP: begin
          if (ph_q == 4'd12) begin
            ph_q <= 4'd0;
            if (j_q == CLast - 1'b1) begin
              j_q <= CW'(1);
              i_q <= i_q + 1'b1;
            end else begin
              j_q <= j_q + 1'b1;
            end
            if (state_d == ST_RESULT) cur_b_q <= ~cur_b_q;
          end else begin
            ph_q <= ph_q + 1'b1;
          end
        end
        ST_RIPPLE, ST_READ: ctr_q <= ctr_q + 1'b1;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
